// ----- hw/rtl/sliding_dft_tone_power_detector_macros.svh -----
// Assertion helpers shared by the detector RTL.
`ifndef SLIDING_DFT_TONE_POWER_DETECTOR_MACROS_SVH
`define SLIDING_DFT_TONE_POWER_DETECTOR_MACROS_SVH

// Same-cycle implication, checked on every rising edge out of reset.
`define SDFT_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("sdft: same-cycle check failed");

// Next-cycle implication.
`define SDFT_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("sdft: next-cycle check failed");

`endif

// ----- hw/rtl/sdft_pkg.sv -----
`timescale 1ns / 1ps
package sdft_pkg;

    localparam int WINDOW_MAX_DEF      = 1024;
    localparam int AVERAGE_MAX_DEF     = 64;
    localparam int SINE_TABLE_BITS_DEF = 10;

    localparam int SAMPLE_W = 16;
    localparam int ROM_W    = 15;
    localparam int PROD_W   = 17;
    localparam int SUM_W    = 40;
    localparam int LEAK_W   = 16;
    localparam int POWER_W  = 48;
    localparam int CFG_W    = 32;
    localparam int WLEN_REG_W = 11;
    localparam int ALEN_REG_W = 7;

    localparam logic [SUM_W-1:0]   SUM_LIMIT = 40'h7F_FFFF_FFFF;
    localparam logic [POWER_W-1:0] POWER_MAX = 48'hFFFF_FFFF_FFFF;

    localparam logic [CFG_W-1:0]      PHASE_INC_RST = 32'd0;
    localparam logic [WLEN_REG_W-1:0] WLEN_RST      = 11'd1024;
    localparam logic [ALEN_REG_W-1:0] ALEN_RST      = 7'd64;
    localparam logic [LEAK_W-1:0]     LEAK_RST      = 16'd65529;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    // Taylor term divisors 2n(2n+1) as rounded-up reciprocals scaled by 2^41;
    // exact floor for the term range of the series (below 2^32)
    localparam int          TAYLOR_SHIFT = 41;
    localparam logic [63:0] TAYLOR_ONE   = 64'd1 << TAYLOR_SHIFT;
    localparam logic [63:0] TAYLOR_RECIP [1:10] = '{
        (TAYLOR_ONE + 64'd5) / 64'd6,
        (TAYLOR_ONE + 64'd19) / 64'd20,
        (TAYLOR_ONE + 64'd41) / 64'd42,
        (TAYLOR_ONE + 64'd71) / 64'd72,
        (TAYLOR_ONE + 64'd109) / 64'd110,
        (TAYLOR_ONE + 64'd155) / 64'd156,
        (TAYLOR_ONE + 64'd209) / 64'd210,
        (TAYLOR_ONE + 64'd271) / 64'd272,
        (TAYLOR_ONE + 64'd341) / 64'd342,
        (TAYLOR_ONE + 64'd419) / 64'd420
    };

    typedef enum logic [1:0] {
        CFG_PHASE_INC = 2'd0,
        CFG_WLEN      = 2'd1,
        CFG_ALEN      = 2'd2,
        CFG_LEAK      = 2'd3
    } cfg_index_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_S,
        ST_MUL_C,
        ST_LEAK_S,
        ST_LEAK_C,
        ST_SUM_C,
        ST_SQ_A,
        ST_SQ_B,
        ST_POWER,
        ST_TOTAL,
        ST_DIV,
        ST_OUT
    } state_t;

    // Quarter-wave sine entry k in unsigned Q0.15, Taylor series in Q2.30.
    function automatic logic [ROM_W-1:0] quarter_sine(input int unsigned k,
                                                       input int unsigned qb);
        logic [63:0]  x;
        logic [63:0]  term;
        logic [127:0] prod;
        longint       acc;
        logic [63:0]  v;
        x    = (HALF_PI_Q30 * 64'(k)) >> qb;
        term = x;
        acc  = longint'(x);
        for (int n = 1; n <= 10; n++) begin
            term = (term * x) >> 30;
            term = (term * x) >> 30;
            prod = 128'(term) * 128'(TAYLOR_RECIP[n]);
            term = 64'(prod >> TAYLOR_SHIFT);
            if (n[0]) begin
                acc = acc - longint'(term);
            end else begin
                acc = acc + longint'(term);
            end
        end
        if (acc < 0) begin
            acc = 0;
        end
        v = (64'(acc) * 64'd32767 + 64'd536870912) >> 30;
        if (v > 64'd32767) begin
            v = 64'd32767;
        end
        return v[ROM_W-1:0];
    endfunction

endpackage

// ----- hw/rtl/sliding_dft_tone_power_detector.sv -----
`timescale 1ns / 1ps
// One sample is in flight at a time: a new sample is taken only in the idle state. The
// average divide is bit-serial, one quotient bit per cycle.
// A result waiting on the output register lets the next sample in, and that sample
// holds in its last step until the register frees.
// Reset (aresetn, synchronous, active low) loads register defaults and empties the
// window and average rings by clearing their fill flags; length writes also empty the rings.
`include "sliding_dft_tone_power_detector_macros.svh"
module sliding_dft_tone_power_detector #(
    parameter int WINDOW_MAX      = sdft_pkg::WINDOW_MAX_DEF,
    parameter int AVERAGE_MAX     = sdft_pkg::AVERAGE_MAX_DEF,
    parameter int SINE_TABLE_BITS = sdft_pkg::SINE_TABLE_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [1:0]                    cfg_index,
    input  logic [sdft_pkg::CFG_W-1:0]    cfg_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [15:0]            s_sample,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [sdft_pkg::POWER_W-1:0]  m_average_power
);

    localparam int WIN_AW  = $clog2(WINDOW_MAX);
    localparam int AVG_AW  = (AVERAGE_MAX > 1) ? $clog2(AVERAGE_MAX) : 1;
    localparam int WLEN_W  = $clog2(WINDOW_MAX + 1);
    localparam int ALEN_W  = $clog2(AVERAGE_MAX + 1);
    localparam int PROD_W  = sdft_pkg::PROD_W;
    localparam int SUM_W   = sdft_pkg::SUM_W;
    localparam int ACC_W   = SUM_W + 1;
    localparam int LMUL_W  = ACC_W + sdft_pkg::LEAK_W;
    localparam int POWER_W = sdft_pkg::POWER_W;
    localparam int TOT_W   = POWER_W + ALEN_W;
    localparam int STB     = SINE_TABLE_BITS;
    localparam int Q       = 1 << (STB - 2);

    sdft_pkg::state_t state_reg, state_next;

    logic [sdft_pkg::CFG_W-1:0]      phase_inc_reg;
    logic [sdft_pkg::WLEN_REG_W-1:0] wlen_reg;
    logic [sdft_pkg::ALEN_REG_W-1:0] alen_reg;
    logic [sdft_pkg::LEAK_W-1:0]     leak_reg;

    logic [31:0]              phase_reg;
    logic [WIN_AW-1:0]        wp_reg;
    logic [AVG_AW-1:0]        ap_reg;
    logic                     win_full_reg;
    logic                     avg_full_reg;
    logic signed [SUM_W-1:0]  sine_sum_reg;
    logic signed [SUM_W-1:0]  cos_sum_reg;
    logic [TOT_W-1:0]         total_reg;

    logic signed [15:0]       sample_reg;
    logic [STB-1:0]           idx_reg;
    logic signed [31:0]       mult_reg;
    logic signed [PROD_W-1:0] sp_reg;
    logic signed [PROD_W-1:0] cp_reg;
    logic [LMUL_W-1:0]        lmul_reg;
    logic                     lneg_reg;
    logic [63:0]              sq_a_reg;
    logic [63:0]              sq_b_reg;
    logic                     ovf_reg;
    logic [POWER_W-1:0]       pw_reg;
    logic                     m_valid_reg;
    logic [POWER_W-1:0]       m_data_reg;

    logic [WLEN_W-1:0]        wlen;
    logic [ALEN_W-1:0]        alen;
    logic                     len_write;
    logic                     s_accept;
    logic                     out_free;
    logic [STB-1:0]           rom_idx;
    logic signed [15:0]       rom_value;
    logic [2*PROD_W-1:0]      win_rd;
    logic [POWER_W-1:0]       hist_rd;
    logic signed [PROD_W-1:0] old_s;
    logic signed [PROD_W-1:0] old_c;
    logic [POWER_W-1:0]       old_h;
    logic signed [ACC_W-1:0]  acc;
    logic [ACC_W-1:0]         acc_mag;
    logic [ACC_W-1:0]         lsh;
    logic [SUM_W-1:0]         lsat;
    logic signed [SUM_W-1:0]  leak_res;
    logic [SUM_W-1:0]         ma;
    logic [SUM_W-1:0]         mb;
    logic [64:0]              sq_tot;
    logic [TOT_W-1:0]         total_next;
    logic [WIN_AW:0]          wp_inc;
    logic [AVG_AW:0]          ap_inc;
    logic                     win_we;
    logic                     hist_we;
    logic                     div_start;
    logic                     div_done;
    logic [TOT_W-1:0]         quotient;

    // effective lengths: zero acts as one, large values clamp to the store depth
    always_comb begin
        if (wlen_reg == '0) begin
            wlen = WLEN_W'(1);
        end else if (32'(wlen_reg) > 32'(WINDOW_MAX)) begin
            wlen = WLEN_W'(WINDOW_MAX);
        end else begin
            wlen = WLEN_W'(wlen_reg);
        end
        if (alen_reg == '0) begin
            alen = ALEN_W'(1);
        end else if (32'(alen_reg) > 32'(AVERAGE_MAX)) begin
            alen = ALEN_W'(AVERAGE_MAX);
        end else begin
            alen = ALEN_W'(alen_reg);
        end
    end

    assign len_write = cfg_we && (cfg_index == sdft_pkg::CFG_WLEN ||
                                  cfg_index == sdft_pkg::CFG_ALEN);
    assign s_ready   = (state_reg == sdft_pkg::ST_IDLE);
    assign s_accept  = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_inc_reg <= sdft_pkg::PHASE_INC_RST;
            wlen_reg      <= sdft_pkg::WLEN_RST;
            alen_reg      <= sdft_pkg::ALEN_RST;
            leak_reg      <= sdft_pkg::LEAK_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                sdft_pkg::CFG_PHASE_INC: phase_inc_reg <= cfg_data;
                sdft_pkg::CFG_WLEN:      wlen_reg <= cfg_data[sdft_pkg::WLEN_REG_W-1:0];
                sdft_pkg::CFG_ALEN:      alen_reg <= cfg_data[sdft_pkg::ALEN_REG_W-1:0];
                sdft_pkg::CFG_LEAK:      leak_reg <= cfg_data[sdft_pkg::LEAK_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- sine ROM ----------------
    assign rom_idx = (state_reg == sdft_pkg::ST_IDLE) ? phase_reg[31 -: STB]
                                                      : idx_reg + STB'(Q);

    sdft_rom #(.SINE_TABLE_BITS(STB)) u_rom (
        .aclk  (aclk),
        .idx   (rom_idx),
        .value (rom_value)
    );

    // ---------------- ring stores ----------------
    assign win_we  = (state_reg == sdft_pkg::ST_SUM_C);
    assign hist_we = (state_reg == sdft_pkg::ST_TOTAL);

    sdft_ram #(.WIDTH(2 * PROD_W), .DEPTH(WINDOW_MAX), .AW(WIN_AW)) u_win_ram (
        .aclk    (aclk),
        .wr_en   (win_we),
        .wr_addr (wp_reg),
        .wr_data ({sp_reg, cp_reg}),
        .rd_addr (wp_reg),
        .rd_data (win_rd)
    );

    sdft_ram #(.WIDTH(POWER_W), .DEPTH(AVERAGE_MAX), .AW(AVG_AW)) u_hist_ram (
        .aclk    (aclk),
        .wr_en   (hist_we),
        .wr_addr (ap_reg),
        .wr_data (pw_reg),
        .rd_addr (ap_reg),
        .rd_data (hist_rd)
    );

    // entries not yet written since the last clear read as zero
    assign old_s = win_full_reg ? $signed(win_rd[2*PROD_W-1:PROD_W]) : '0;
    assign old_c = win_full_reg ? $signed(win_rd[PROD_W-1:0]) : '0;
    assign old_h = avg_full_reg ? hist_rd : '0;

    // ---------------- leak datapath ----------------
    always_comb begin
        if (state_reg == sdft_pkg::ST_LEAK_S) begin
            acc = ACC_W'(sine_sum_reg) - ACC_W'(old_s) + ACC_W'(sp_reg);
        end else begin
            acc = ACC_W'(cos_sum_reg) - ACC_W'(old_c) + ACC_W'(cp_reg);
        end
        acc_mag  = acc[ACC_W-1] ? ACC_W'(-acc) : ACC_W'(acc);
        lsh      = lmul_reg[LMUL_W-1:sdft_pkg::LEAK_W];
        lsat     = (lsh > ACC_W'(sdft_pkg::SUM_LIMIT)) ? sdft_pkg::SUM_LIMIT
                                                        : lsh[SUM_W-1:0];
        leak_res = lneg_reg ? -$signed(lsat) : $signed(lsat);
    end

    assign ma     = sine_sum_reg[SUM_W-1] ? SUM_W'(-sine_sum_reg) : SUM_W'(sine_sum_reg);
    assign mb     = cos_sum_reg[SUM_W-1] ? SUM_W'(-cos_sum_reg) : SUM_W'(cos_sum_reg);
    assign sq_tot = {1'b0, sq_a_reg} + {1'b0, sq_b_reg};

    assign total_next = total_reg - TOT_W'(old_h) + TOT_W'(pw_reg);
    assign wp_inc     = {1'b0, wp_reg} + (WIN_AW+1)'(1);
    assign ap_inc     = {1'b0, ap_reg} + (AVG_AW+1)'(1);
    assign div_start  = hist_we;

    sdft_div #(.DVD_W(TOT_W), .DVS_W(ALEN_W)) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (total_next),
        .divisor  (alen),
        .done     (div_done),
        .quotient (quotient)
    );

    // ---------------- control ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= sdft_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            sdft_pkg::ST_IDLE:   if (s_valid) state_next = sdft_pkg::ST_MUL_S;
            sdft_pkg::ST_MUL_S:  state_next = sdft_pkg::ST_MUL_C;
            sdft_pkg::ST_MUL_C:  state_next = sdft_pkg::ST_LEAK_S;
            sdft_pkg::ST_LEAK_S: state_next = sdft_pkg::ST_LEAK_C;
            sdft_pkg::ST_LEAK_C: state_next = sdft_pkg::ST_SUM_C;
            sdft_pkg::ST_SUM_C:  state_next = sdft_pkg::ST_SQ_A;
            sdft_pkg::ST_SQ_A:   state_next = sdft_pkg::ST_SQ_B;
            sdft_pkg::ST_SQ_B:   state_next = sdft_pkg::ST_POWER;
            sdft_pkg::ST_POWER:  state_next = sdft_pkg::ST_TOTAL;
            sdft_pkg::ST_TOTAL:  state_next = sdft_pkg::ST_DIV;
            sdft_pkg::ST_DIV:    if (div_done) state_next = sdft_pkg::ST_OUT;
            sdft_pkg::ST_OUT:    if (out_free) state_next = sdft_pkg::ST_IDLE;
            default:             state_next = sdft_pkg::ST_IDLE;
        endcase
    end

    // ring state, sums and running total
    always_ff @(posedge aclk) begin
        if (!aresetn || len_write) begin
            phase_reg    <= '0;
            wp_reg       <= '0;
            ap_reg       <= '0;
            win_full_reg <= 1'b0;
            avg_full_reg <= 1'b0;
            sine_sum_reg <= '0;
            cos_sum_reg  <= '0;
            total_reg    <= '0;
        end else begin
            if (s_accept) begin
                phase_reg <= phase_reg + phase_inc_reg;
            end
            if (state_reg == sdft_pkg::ST_LEAK_C) begin
                sine_sum_reg <= leak_res;
            end
            if (win_we) begin
                cos_sum_reg <= leak_res;
                if (32'(wp_inc) >= 32'(wlen)) begin
                    wp_reg       <= '0;
                    win_full_reg <= 1'b1;
                end else begin
                    wp_reg <= wp_inc[WIN_AW-1:0];
                end
            end
            if (hist_we) begin
                total_reg <= total_next;
                if (32'(ap_inc) >= 32'(alen)) begin
                    ap_reg       <= '0;
                    avg_full_reg <= 1'b1;
                end else begin
                    ap_reg <= ap_inc[AVG_AW-1:0];
                end
            end
        end
    end

    // per-sample working registers
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            sample_reg <= s_sample;
            idx_reg    <= phase_reg[31 -: STB];
        end
        if (state_reg == sdft_pkg::ST_MUL_S || state_reg == sdft_pkg::ST_MUL_C) begin
            mult_reg <= sample_reg * rom_value;
        end
        if (state_reg == sdft_pkg::ST_MUL_C) begin
            sp_reg <= mult_reg[31:15];
        end
        if (state_reg == sdft_pkg::ST_LEAK_S) begin
            cp_reg <= mult_reg[31:15];
        end
        if (state_reg == sdft_pkg::ST_LEAK_S || state_reg == sdft_pkg::ST_LEAK_C) begin
            lmul_reg <= acc_mag * leak_reg;
            lneg_reg <= acc[ACC_W-1];
        end
        if (state_reg == sdft_pkg::ST_SQ_A) begin
            sq_a_reg <= ma[31:0] * ma[31:0];
            ovf_reg  <= |ma[SUM_W-1:32];
        end
        if (state_reg == sdft_pkg::ST_SQ_B) begin
            sq_b_reg <= mb[31:0] * mb[31:0];
            ovf_reg  <= ovf_reg | (|mb[SUM_W-1:32]);
        end
        if (state_reg == sdft_pkg::ST_POWER) begin
            pw_reg <= (ovf_reg || sq_tot[64]) ? sdft_pkg::POWER_MAX : sq_tot[63:16];
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (state_reg == sdft_pkg::ST_OUT && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == sdft_pkg::ST_OUT && out_free) begin
            m_data_reg <= (|quotient[TOT_W-1:POWER_W]) ? sdft_pkg::POWER_MAX
                                                       : quotient[POWER_W-1:0];
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_average_power = m_data_reg;

    // ---------------- checks ----------------
    `SDFT_ASSERT_NEXT(a_one_in_flight, aclk, aresetn, s_valid && s_ready, !s_ready)
    `SDFT_ASSERT_NOW(a_wp_range, aclk, aresetn, 1'b1, 32'(wp_reg) < 32'(wlen))
    `SDFT_ASSERT_NOW(a_ap_range, aclk, aresetn, 1'b1, 32'(ap_reg) < 32'(alen))
    `SDFT_ASSERT_NEXT(a_div_to_out, aclk, aresetn,
                      state_reg == sdft_pkg::ST_DIV && div_done,
                      state_reg == sdft_pkg::ST_OUT)

endmodule

// ----- hw/rtl/sdft_ram.sv -----
`timescale 1ns / 1ps
module sdft_ram #(
    parameter int WIDTH = 34,
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- hw/rtl/sdft_rom.sv -----
`timescale 1ns / 1ps
module sdft_rom #(
    parameter int SINE_TABLE_BITS = sdft_pkg::SINE_TABLE_BITS_DEF
) (
    input  logic                       aclk,
    input  logic [SINE_TABLE_BITS-1:0] idx,
    output logic signed [15:0]         value
);

    localparam int QB = SINE_TABLE_BITS - 2;
    localparam int Q  = 1 << QB;

    logic [sdft_pkg::ROM_W-1:0] qtab [Q+1];
    logic [1:0]                 quad;
    logic [QB-1:0]              k;
    logic [QB:0]                taddr;
    logic [sdft_pkg::ROM_W-1:0] mag_reg;
    logic                       neg_reg;

    for (genvar g = 0; g <= Q; g++) begin : g_tab
        assign qtab[g] = sdft_pkg::quarter_sine(g, QB);
    end

    assign quad  = idx[SINE_TABLE_BITS-1 -: 2];
    assign k     = idx[QB-1:0];
    // odd quadrants run the table backward
    assign taddr = quad[0] ? ((QB+1)'(Q) - {1'b0, k}) : {1'b0, k};

    always_ff @(posedge aclk) begin
        mag_reg <= qtab[taddr];
        neg_reg <= quad[1];
    end

    assign value = neg_reg ? -$signed({1'b0, mag_reg}) : $signed({1'b0, mag_reg});

endmodule

// ----- hw/rtl/sdft_div.sv -----
`timescale 1ns / 1ps
module sdft_div #(
    parameter int DVD_W = 55,
    parameter int DVS_W = 7
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic             done,
    output logic [DVD_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [DVS_W-1:0] rem_reg;
    logic [DVD_W-1:0] quo_reg;
    logic [DVS_W-1:0] dvs_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [DVS_W:0]   trial;
    logic             fits;
    logic [DVS_W:0]   diff;

    assign trial = {rem_reg, quo_reg[DVD_W-1]};
    assign fits  = trial >= {1'b0, dvs_reg};
    assign diff  = trial - {1'b0, dvs_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && cnt_reg == CNT_W'(1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // one quotient bit per cycle, restoring
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
            cnt_reg <= CNT_W'(DVD_W);
        end else if (busy_reg) begin
            rem_reg <= fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
            quo_reg <= {quo_reg[DVD_W-2:0], fits};
            cnt_reg <= cnt_reg - CNT_W'(1);
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ----- tb/sv/sliding_dft_tone_power_detector_tb.sv -----
`timescale 1ns / 1ps
module sliding_dft_tone_power_detector_tb;
    import sdft_pkg::*;

    class tone_power_scoreboard;
        localparam int QSIZE = 1 << (SINE_TABLE_BITS_DEF - 2);
        int             sine_rom [QSIZE+1];
        logic [31:0]    phase_step;
        logic [10:0]    win_reg;
        logic [6:0]     avg_reg;
        logic [15:0]    leak;
        longint         sin_ring [WINDOW_MAX_DEF];
        longint         cos_ring [WINDOW_MAX_DEF];
        longint         sin_acc;
        longint         cos_acc;
        int             win_pos;
        logic [31:0]    phase;
        longint unsigned pow_ring [AVERAGE_MAX_DEF];
        longint unsigned pow_total;
        int             avg_pos;
        logic [47:0]    expected_power [$];
        int             errors;
        int             checked;

        function new();
            longint unsigned x, term, v;
            longint acc;
            for (int k = 0; k <= QSIZE; k++) begin
                x = (64'd1686629713 * 64'(k)) / QSIZE;
                term = x;
                acc = longint'(x);
                for (int n = 1; n <= 10; n++) begin
                    term = (term * x) >> 30;
                    term = (term * x) >> 30;
                    term = term / (64'(2 * n) * 64'(2 * n + 1));
                    if (n % 2 == 1) acc = acc - longint'(term);
                    else acc = acc + longint'(term);
                end
                if (acc < 0) acc = 0;
                v = (64'(acc) * 64'd32767 + 64'd536870912) >> 30;
                sine_rom[k] = (v > 32767) ? 32767 : int'(v);
            end
            phase_step = PHASE_INC_RST;
            win_reg = WLEN_RST;
            avg_reg = ALEN_RST;
            leak = LEAK_RST;
            errors = 0;
            checked = 0;
            clear_all();
        endfunction

        function void clear_all();
            foreach (sin_ring[i]) begin
                sin_ring[i] = 0;
                cos_ring[i] = 0;
            end
            foreach (pow_ring[i]) pow_ring[i] = 0;
            sin_acc = 0;
            cos_acc = 0;
            win_pos = 0;
            phase = 0;
            pow_total = 0;
            avg_pos = 0;
        endfunction

        function void write_reg(cfg_index_t idx, logic [31:0] d);
            case (idx)
                CFG_PHASE_INC: phase_step = d;
                CFG_WLEN: begin win_reg = d[10:0]; clear_all(); end
                CFG_ALEN: begin avg_reg = d[6:0]; clear_all(); end
                CFG_LEAK: leak = d[15:0];
                default: ;
            endcase
        endfunction

        function int sine_at(int unsigned idx);
            int unsigned k;
            k = idx % QSIZE;
            case ((idx / QSIZE) % 4)
                0: return sine_rom[k];
                1: return sine_rom[QSIZE - k];
                2: return -sine_rom[k];
                default: return -sine_rom[QSIZE - k];
            endcase
        endfunction

        function longint leaky(longint acc, longint oldest, longint fresh);
            longint s, r;
            longint unsigned mag;
            s = acc - oldest + fresh;
            mag = (s < 0) ? -s : s;
            mag = (mag * leak) >> 16;
            r = (s < 0) ? -longint'(mag) : longint'(mag);
            if (r > 64'sd549755813887) r = 64'sd549755813887;
            if (r < -64'sd549755813887) r = -64'sd549755813887;
            return r;
        endfunction

        function void note_sample(logic signed [15:0] smp);
            int wlen, alen, wp, ap;
            int unsigned idx;
            longint sp, cp;
            longint unsigned ma, mb, pw;
            logic [64:0] sq;
            wlen = (win_reg == 0) ? 1 : (win_reg > WINDOW_MAX_DEF) ? WINDOW_MAX_DEF : win_reg;
            alen = (avg_reg == 0) ? 1 : (avg_reg > AVERAGE_MAX_DEF) ? AVERAGE_MAX_DEF : avg_reg;
            idx = phase >> (32 - SINE_TABLE_BITS_DEF);
            // floor shift keeps rounding toward minus infinity
            sp = (longint'(smp) * sine_at(idx)) >>> 15;
            cp = (longint'(smp) * sine_at((idx + QSIZE) % (1 << SINE_TABLE_BITS_DEF))) >>> 15;
            phase = phase + phase_step;
            wp = (win_pos < wlen) ? win_pos : 0;
            sin_acc = leaky(sin_acc, sin_ring[wp], sp);
            cos_acc = leaky(cos_acc, cos_ring[wp], cp);
            sin_ring[wp] = sp;
            cos_ring[wp] = cp;
            win_pos = (wp + 1 >= wlen) ? 0 : wp + 1;
            ma = (sin_acc < 0) ? -sin_acc : sin_acc;
            mb = (cos_acc < 0) ? -cos_acc : cos_acc;
            if (ma >= 64'h1_0000_0000 || mb >= 64'h1_0000_0000) begin
                pw = 64'hFFFF_FFFF_FFFF;
            end else begin
                sq = 65'(ma * ma) + 65'(mb * mb);
                if (sq[64]) pw = 64'hFFFF_FFFF_FFFF;
                else begin
                    pw = sq[63:0] >> 16;
                    if (pw > 64'hFFFF_FFFF_FFFF) pw = 64'hFFFF_FFFF_FFFF;
                end
            end
            ap = (avg_pos < alen) ? avg_pos : 0;
            pow_total = pow_total - pow_ring[ap] + pw;
            pow_ring[ap] = pw;
            avg_pos = (ap + 1 >= alen) ? 0 : ap + 1;
            pw = pow_total / alen;
            if (pw > 64'hFFFF_FFFF_FFFF) pw = 64'hFFFF_FFFF_FFFF;
            expected_power.push_back(pw[47:0]);
        endfunction

        function void check_power(logic [47:0] got);
            logic [47:0] want;
            checked++;
            if (expected_power.size() == 0) begin
                $error("average_power: unexpected beat, actual %0d", got);
                errors++;
                return;
            end
            want = expected_power.pop_front();
            if (got !== want) begin
                $error("average_power: expected %0d, actual %0d", want, got);
                errors++;
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;
    logic        s_valid;
    logic        s_ready;
    logic signed [15:0] s_sample;
    logic        m_valid;
    logic        m_ready;
    logic [47:0] m_average_power;

    tone_power_scoreboard sb;
    bit quiet;
    int samples_sent;
    int settings_used;

    sliding_dft_tone_power_detector dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_sample(s_sample),
        .m_valid(m_valid), .m_ready(m_ready), .m_average_power(m_average_power)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        m_ready <= quiet ? 1'b1 : ($urandom_range(99) >= 19);
        if (aresetn && m_valid && m_ready) sb.check_power(m_average_power);
    end

    task automatic push_sample(logic signed [15:0] v);
        s_valid <= 1'b1;
        s_sample <= v;
        do @(posedge aclk); while (!s_ready);
        sb.note_sample(v);
        samples_sent++;
        if (!quiet && $urandom_range(99) < 19) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (sb.expected_power.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
    endtask

    task automatic apply_settings(logic [31:0] step, logic [31:0] wl, logic [31:0] al,
                                  logic [31:0] lk);
        cfg_index_t order [4];
        logic [31:0] vals [4];
        order = '{CFG_PHASE_INC, CFG_WLEN, CFG_ALEN, CFG_LEAK};
        vals = '{step, wl, al, lk};
        for (int i = 0; i < 4; i++) begin
            cfg_we <= 1'b1;
            cfg_index <= order[i];
            cfg_data <= vals[i];
            @(posedge aclk);
            sb.write_reg(order[i], vals[i]);
        end
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    function automatic logic signed [15:0] pick_sample(int n, logic [31:0] step);
        int r, amp;
        longint v;
        r = $urandom_range(99);
        if (r < 55) begin
            // tone near the configured bin plus some noise
            amp = $urandom_range(32000);
            v = (longint'(amp) * sb.sine_at(((step * n) >> 22) % 1024)) >>> 15;
            v = v + $signed($urandom_range(512)) - 256;
            if (v > 32767) v = 32767;
            if (v < -32768) v = -32768;
            return 16'(v);
        end
        if (r < 85) return 16'($urandom);
        if (r < 95) return ($urandom_range(1)) ? 16'sh7FFF : -16'sh8000;
        return 16'($signed($urandom_range(8)) - 4);
    endfunction

    initial begin
        logic signed [15:0] edge_vals [6];
        logic [31:0] step;
        int wl_max;
        aclk = 1'b0;
        aresetn = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_PHASE_INC;
        cfg_data = '0;
        s_valid = 1'b0;
        s_sample = '0;
        m_ready = 1'b0;
        quiet = 1'b0;
        samples_sent = 0;
        settings_used = 0;
        sb = new();
        edge_vals = '{16'sh7FFF, -16'sh8000, 16'sh0000, -16'sh0001, 16'sh0001, 16'sh5A5A};
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset defaults first, then short, zero and over-range lengths with extreme samples
        for (int i = 0; i < 4; i++) push_sample(edge_vals[i]);
        drain();
        apply_settings(32'h4000_0000, 4, 2, 65535);
        for (int i = 0; i < 12; i++) push_sample(edge_vals[i % 6]);
        drain();
        apply_settings(32'd0, 0, 0, 0);
        for (int i = 0; i < 5; i++) push_sample(edge_vals[i]);
        drain();
        apply_settings(32'hFFFF_FFFF, 2047, 127, 65535);
        for (int i = 0; i < 4; i++) push_sample(edge_vals[5 - i]);
        drain();

        for (int p = 0; p < 8; p++) begin
            wl_max = (p == 2) ? 1024 : 64;
            case (p)
                0: apply_settings(32'h0147_AE14, 16, 8, LEAK_RST);
                1: apply_settings(32'h8000_0000, 1, 1, 65535);
                2: apply_settings($urandom, 1024, 64, 65535);
                default: apply_settings($urandom, $urandom_range(1, wl_max),
                                        $urandom_range(1, 64), $urandom_range(65535));
            endcase
            step = sb.phase_step;
            for (int n = 0; n < 210; n++) begin
                quiet = (p == 4);
                push_sample(pick_sample(n, step));
            end
            quiet = 1'b0;
            drain();
        end

        $display("Sent %0d samples over %0d register settings, %0d power beats checked.",
                 samples_sent, settings_used, sb.checked);
        if (sb.errors == 0 && sb.expected_power.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("Regression FAIL");
        $finish;
    end
endmodule
